// ----- rtl/pra_pkg.sv -----
// Shared constants and types for the page run allocator.
package pra_pkg;

  localparam int unsigned NumPages = 1024;
  localparam int unsigned PageW    = $clog2(NumPages);
  localparam int unsigned CntW     = PageW + 1;
  localparam int unsigned ReqW     = CntW;
  localparam int unsigned FreeW    = PageW;
  localparam int unsigned StatW    = 2;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  typedef logic [1:0]       pg_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [StatW-1:0] status_t;

  localparam pg_t PgFree   = 2'd0;
  localparam pg_t PgMarked = 2'd1;
  localparam pg_t PgRstart = 2'd2;

  localparam status_t StatusOk      = 2'd0;
  localparam status_t StatusNoSpace = 2'd1;
  localparam status_t StatusOutside = 2'd2;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [AddrW-3:0] RegRegionStart = '0;

endpackage

// ----- rtl/pra_if.sv -----
// Request and response channel interfaces.
interface pra_req_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [pra_pkg::ReqW-1:0]  req_pages;
  logic [pra_pkg::FreeW-1:0] run_page;
  modport source (output valid, cmd, req_pages, run_page, input ready);
  modport sink   (input valid, cmd, req_pages, run_page, output ready);
endinterface

interface pra_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [pra_pkg::StatW-1:0] status;
  logic [pra_pkg::PageW-1:0] start_page;
  logic [pra_pkg::CntW-1:0]  pages_freed;
  logic [pra_pkg::CntW-1:0]  break_page;
  modport source (output valid, status, start_page, pages_freed, break_page, input ready);
  modport sink   (input valid, status, start_page, pages_freed, break_page, output ready);
endinterface

// ----- rtl/pra_cell.sv -----
// One page entry of the rotating page map.
module pra_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  pra_pkg::pg_t  d_i,
  output pra_pkg::pg_t  q_o
);

  pra_pkg::pg_t pg_q;

  // Take the neighbour's entry on each shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q <= pra_pkg::PgFree;
    end else if (shift_i) begin
      pg_q <= d_i;
    end
  end

  assign q_o = pg_q;

endmodule

// ----- rtl/pra_ring.sv -----
// Ring of page cells; the head entry is updated and re-enters at the tail.
module pra_ring (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  pra_pkg::pg_t  tail_i,
  output pra_pkg::pg_t  head_o
);

  pra_pkg::pg_t link [pra_pkg::NumPages];

  for (genvar g = 0; g < pra_pkg::NumPages; g++) begin : g_cell
    pra_pkg::pg_t d;
    if (g == pra_pkg::NumPages - 1) begin : g_tail
      assign d = tail_i;
    end else begin : g_mid
      assign d = link[g+1];
    end
    pra_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .d_i     (d),
      .q_o     (link[g])
    );
  end

  assign head_o = link[0];

endmodule

// ----- rtl/page_run_allocator.sv -----
// Top level of the page run allocator: control, break pointer and config port.
//
//  channel  dir  handshake       payload
//  req_i    in   valid/ready     cmd, req_pages, run_page
//  rsp_o    out  valid/ready     status, start_page, pages_freed, break_page
//  apb      in   psel/penable    paddr, pwdata, prdata
//
// The page map rotates through a ring of NumPages cells, one page per cycle while a scan,
// mark or clear revolution runs. Allocate: one scan revolution, then one marking revolution
// if a place is found. Free: one clearing revolution; bad requests skip the ring.
// Reset clears the whole map at once; the break starts at the region start.
// A result waits in the output register; the next request is taken meanwhile.
module page_run_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pra_req_if.sink                      req_i,
  pra_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pra_pkg::AddrW-1:0]    paddr,
  input  logic [pra_pkg::DataW-1:0]    pwdata,
  output logic [pra_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_MARK   = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [pra_pkg::ReqW-1:0] region_q;
  pra_pkg::cnt_t brk_q, brk_d, lo;
  pra_pkg::cnt_t pos_q, pos_d;
  pra_pkg::cnt_t n_q, n_d;
  logic [pra_pkg::FreeW-1:0] fp_q, fp_d;
  pra_pkg::cnt_t run_len_q, run_len_d, run_start_q, run_start_d;
  pra_pkg::cnt_t best_len_q, best_len_d, best_start_q, best_start_d;
  logic found_q, found_d;
  pra_pkg::cnt_t where_q, where_d;
  logic [pra_pkg::CntW:0] end_q, end_d;
  logic clearing_q, clearing_d;
  pra_pkg::cnt_t freed_q, freed_d, newbrk_q, newbrk_d;
  pra_pkg::status_t res_status_q, res_status_d;

  logic rsp_valid_q;
  pra_pkg::status_t out_status_q;
  logic [pra_pkg::PageW-1:0] out_start_q;
  pra_pkg::cnt_t out_freed_q, out_brk_q;

  logic shift, last_step, in_rng, clr, cfg_wr, load_out;
  pra_pkg::pg_t head, tail;
  pra_pkg::cnt_t fin_len, fin_start;
  logic fin_found;
  logic [pra_pkg::CntW:0] brk_sum;

  assign lo = (region_q > pra_pkg::ReqW'(pra_pkg::NumPages)) ?
              pra_pkg::CntW'(pra_pkg::NumPages) : region_q;
  assign shift     = (state_q == S_SCAN) || (state_q == S_MARK) || (state_q == S_CLEAR);
  assign last_step = (pos_q == pra_pkg::CntW'(pra_pkg::NumPages - 1));
  assign in_rng    = (pos_q >= lo) && (pos_q < brk_q);
  assign clr = (pos_q == {1'b0, fp_q}) ||
               (clearing_q && (head != pra_pkg::PgRstart) && (head != pra_pkg::PgFree));
  assign brk_sum = {1'b0, brk_q} + {1'b0, n_q};

  pra_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .tail_i  (tail),
    .head_o  (head)
  );

  // Fold in the run still open at the end of the scan
  always_comb begin
    fin_found = found_q;
    fin_len   = best_len_q;
    fin_start = best_start_q;
    if (!found_q && (run_len_q != '0)) begin
      if (run_len_q == n_q) begin
        fin_found = 1'b1;
      end else if (run_len_q > best_len_q) begin
        fin_len   = run_len_q;
        fin_start = run_start_q;
      end
    end
  end

  // Head update for the current revolution
  always_comb begin
    tail = head;
    case (state_q)
      S_MARK: begin
        if (pos_q == where_q) begin
          tail = pra_pkg::PgRstart;
        end else if (pos_q > where_q && {1'b0, pos_q} < end_q) begin
          tail = pra_pkg::PgMarked;
        end
      end
      S_CLEAR: begin
        if (clr) tail = pra_pkg::PgFree;
      end
      default: tail = head;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    n_d          = n_q;
    fp_d         = fp_q;
    brk_d        = brk_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    found_d      = found_q;
    where_d      = where_q;
    end_d        = end_q;
    clearing_d   = clearing_q;
    freed_d      = freed_q;
    newbrk_d     = newbrk_q;
    res_status_d = res_status_q;
    load_out     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          n_d          = req_i.req_pages;
          fp_d         = req_i.run_page;
          pos_d        = '0;
          run_len_d    = '0;
          best_len_d   = '0;
          best_start_d = '0;
          found_d      = 1'b0;
          where_d      = '0;
          clearing_d   = 1'b0;
          freed_d      = '0;
          newbrk_d     = lo;
          res_status_d = pra_pkg::StatusOk;
          if (req_i.cmd == pra_pkg::CmdAlloc) begin
            if (req_i.req_pages == '0) begin
              res_status_d = pra_pkg::StatusNoSpace;
              state_d      = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end else if ({1'b0, req_i.run_page} < lo ||
                       {1'b0, req_i.run_page} >= pra_pkg::CntW'(pra_pkg::NumPages)) begin
            res_status_d = pra_pkg::StatusOutside;
            state_d      = S_DONE;
          end else begin
            state_d = S_CLEAR;
          end
        end
      end
      S_SCAN: begin
        if (in_rng && !found_q) begin
          if (head == pra_pkg::PgFree) begin
            if (run_len_q == '0) run_start_d = pos_q;
            run_len_d = run_len_q + 1'b1;
          end else begin
            if (run_len_q == n_q) begin
              found_d = 1'b1;
              where_d = run_start_q;
            end else if (run_len_q > best_len_q) begin
              best_len_d   = run_len_q;
              best_start_d = run_start_q;
            end
            run_len_d = '0;
          end
        end
        pos_d = pos_q + 1'b1;
        if (last_step) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        pos_d   = '0;
        state_d = S_MARK;
        if (fin_found) begin
          if (!found_q) where_d = run_start_q;
        end else if (fin_len != '0 && fin_len >= n_q) begin
          where_d = fin_start;
        end else if (brk_sum <= (pra_pkg::CntW+1)'(pra_pkg::NumPages)) begin
          where_d = brk_q;
          brk_d   = brk_sum[pra_pkg::CntW-1:0];
        end else begin
          res_status_d = pra_pkg::StatusNoSpace;
          state_d      = S_DONE;
        end
        end_d = {1'b0, where_d} + {1'b0, n_q};
      end
      S_MARK: begin
        pos_d = pos_q + 1'b1;
        if (last_step) state_d = S_DONE;
      end
      S_CLEAR: begin
        clearing_d = clr;
        if (clr) freed_d = freed_q + 1'b1;
        if (tail != pra_pkg::PgFree && pos_q >= lo && pos_q < brk_q) begin
          newbrk_d = pos_q + 1'b1;
        end
        pos_d = pos_q + 1'b1;
        if (last_step) begin
          if (brk_q > lo) brk_d = newbrk_d;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[pra_pkg::AddrW-1:2] == pra_pkg::RegRegionStart);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      region_q    <= '0;
      brk_q       <= '0;
      rsp_valid_q <= 1'b0;
      clearing_q  <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clearing_q <= clearing_d;
      found_q    <= found_d;
      if (cfg_wr) begin
        region_q <= pwdata[pra_pkg::ReqW-1:0];
        brk_q    <= (pwdata[pra_pkg::ReqW-1:0] > pra_pkg::ReqW'(pra_pkg::NumPages)) ?
                    pra_pkg::CntW'(pra_pkg::NumPages) : pwdata[pra_pkg::ReqW-1:0];
      end else begin
        brk_q <= brk_d;
      end
      if (load_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    n_q          <= n_d;
    fp_q         <= fp_d;
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    where_q      <= where_d;
    end_q        <= end_d;
    freed_q      <= freed_d;
    newbrk_q     <= newbrk_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_brk_q    <= brk_q;
      out_start_q  <= '0;
      out_freed_q  <= '0;
      if (res_status_q == pra_pkg::StatusOk) begin
        out_start_q <= where_q[pra_pkg::PageW-1:0];
        out_freed_q <= freed_q;
      end
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.start_page  = out_start_q;
  assign rsp_o.pages_freed = out_freed_q;
  assign rsp_o.break_page  = out_brk_q;
  assign pready            = 1'b1;
  assign prdata = (paddr[pra_pkg::AddrW-1:2] == pra_pkg::RegRegionStart) ?
                  pra_pkg::DataW'(region_q) : '0;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_brk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= pra_pkg::CntW'(pra_pkg::NumPages)) else $error("break beyond map");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> pos_q < pra_pkg::CntW'(pra_pkg::NumPages)) else $error("ring position overrun");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> rsp_valid_q && state_q == S_IDLE) else $error("result not presented");
`endif

endmodule

// ----- tb/pra_tb_pkg.sv -----
// Scoreboard for the page run allocator: map model and expected-result queue.
package pra_tb_pkg;

  typedef struct packed {
    pra_pkg::status_t            status;
    logic [pra_pkg::PageW-1:0]   start_page;
    pra_pkg::cnt_t               pages_freed;
    pra_pkg::cnt_t               break_page;
  } alloc_result_t;

  class page_run_scoreboard;
    pra_pkg::pg_t    pages[pra_pkg::NumPages];
    int unsigned     brk;
    int unsigned     region;
    alloc_result_t   pending[$];
    int unsigned     errors;
    int unsigned     n_alloc_ok, n_nospace, n_free_ok, n_outside, n_checked;

    function new();
      foreach (pages[i]) pages[i] = pra_pkg::PgFree;
      brk = 0;
      region = 0;
      errors = 0;
    endfunction

    function int unsigned lo_page();
      return (region > pra_pkg::NumPages) ? pra_pkg::NumPages : region;
    endfunction

    function void set_region(int unsigned v);
      region = v & 11'h7ff;
      brk = lo_page();
    endfunction

    // Exact fit first, else first strictly largest run that holds n pages.
    function bit fit_run(int unsigned n, output int unsigned where);
      int unsigned run_len, run_start, best_len, best_start, lim;
      run_len = 0; run_start = 0; best_len = 0; best_start = 0; where = 0;
      lim = (brk > pra_pkg::NumPages) ? pra_pkg::NumPages : brk;
      for (int unsigned p = lo_page(); p < lim; p++) begin
        if (pages[p] == pra_pkg::PgFree) begin
          if (run_len == 0) run_start = p;
          run_len++;
        end else begin
          if (run_len == n) begin
            where = run_start;
            return 1;
          end
          if (run_len > best_len) begin
            best_len = run_len;
            best_start = run_start;
          end
          run_len = 0;
        end
      end
      if (run_len != 0) begin
        if (run_len == n) begin
          where = run_start;
          return 1;
        end
        if (run_len > best_len) begin
          best_len = run_len;
          best_start = run_start;
        end
      end
      if (best_len != 0 && best_len >= n) begin
        where = best_start;
        return 1;
      end
      return 0;
    endfunction

    function void mark(int unsigned first, int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (first + i < pra_pkg::NumPages) pages[first + i] = pra_pkg::PgMarked;
      if (first < pra_pkg::NumPages) pages[first] = pra_pkg::PgRstart;
    endfunction

    // Note an accepted request and queue its expected result.
    function void note_request(logic cmd, int unsigned n, int unsigned fp);
      alloc_result_t r;
      int unsigned where, p, freed;
      r = '0;
      freed = 0;
      if (cmd == pra_pkg::CmdAlloc) begin
        if (n == 0) begin
          r.status = pra_pkg::StatusNoSpace;
        end else if (fit_run(n, where)) begin
          mark(where, n);
          r.start_page = pra_pkg::PageW'(where);
        end else if (brk + n <= pra_pkg::NumPages) begin
          where = brk;
          brk += n;
          mark(where, n);
          r.start_page = pra_pkg::PageW'(where);
        end else begin
          r.status = pra_pkg::StatusNoSpace;
        end
      end else begin
        if (fp < lo_page() || fp >= pra_pkg::NumPages) begin
          r.status = pra_pkg::StatusOutside;
        end else begin
          p = fp;
          while (p < pra_pkg::NumPages &&
                 (p == fp || (pages[p] != pra_pkg::PgRstart &&
                              pages[p] != pra_pkg::PgFree))) begin
            pages[p] = pra_pkg::PgFree;
            p++;
            freed++;
          end
          while (brk > lo_page() && brk <= pra_pkg::NumPages &&
                 pages[brk-1] == pra_pkg::PgFree) brk--;
        end
      end
      r.pages_freed = pra_pkg::CntW'(freed);
      r.break_page = pra_pkg::CntW'(brk);
      case (r.status)
        pra_pkg::StatusNoSpace: n_nospace++;
        pra_pkg::StatusOutside: n_outside++;
        default: if (cmd == pra_pkg::CmdAlloc) n_alloc_ok++; else n_free_ok++;
      endcase
      pending.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d start=%0d", got.status, got.start_page);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.start_page !== exp_r.start_page) begin
        $error("start_page: expected %0d, got %0d", exp_r.start_page, got.start_page);
        errors++;
      end
      if (got.pages_freed !== exp_r.pages_freed) begin
        $error("pages_freed: expected %0d, got %0d", exp_r.pages_freed, got.pages_freed);
        errors++;
      end
      if (got.break_page !== exp_r.break_page) begin
        $error("break_page: expected %0d, got %0d", exp_r.break_page, got.break_page);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- tb/tb_page_run_allocator.sv -----
// Testbench top for the page run allocator: stimulus, idling and result checks.
module tb_page_run_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pra_pkg::AddrW-1:0] paddr = '0;
  logic [pra_pkg::DataW-1:0] pwdata = '0;
  logic [pra_pkg::DataW-1:0] prdata;
  logic pready;

  pra_req_if req_if ();
  pra_rsp_if rsp_if ();

  page_run_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pra_tb_pkg::page_run_scoreboard sb = new();
  bit           calm = 1'b0;      // no idle bursts or receiver stalls in the last part
  int unsigned  hold_off = 0;     // long receiver stall request, in cycles
  longint unsigned cycles = 0;
  localparam longint unsigned CycleLimit = 64'd8_000_000;

  always #10 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = pra_pkg::CmdAlloc;
    req_if.req_pages = '0;
    req_if.run_page = '0;
    rsp_if.ready = 1'b0;
  end

  // Limit the run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receive results with random stalls and one long hold-off.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result({rsp_if.status, rsp_if.start_page, rsp_if.pages_freed,
                         rsp_if.break_page});
      if (hold_off != 0) begin
        rsp_if.ready <= 1'b0;
        hold_off--;
      end else if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  task automatic apb_write(input int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {pra_pkg::RegRegionStart, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_region(value);
  endtask

  // Send one request, with an optional idle burst before it.
  task automatic send(input logic cmd, input int unsigned n, input int unsigned fp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.req_pages <= n[pra_pkg::ReqW-1:0];
    req_if.run_page <= fp[pra_pkg::FreeW-1:0];
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(cmd, n & 32'h7ff, fp & 32'h3ff);
  endtask

  task automatic go_idle();
    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  // Mostly small runs, allocate-heavy, frees aimed near the region start.
  task automatic random_phase(input int unsigned count, input int unsigned span);
    int unsigned n, fp;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 19))
          0: n = $urandom_range(0, 2047);
          1: n = $urandom_range(100, 1024);
          default: n = $urandom_range(1, 12);
        endcase
        send(pra_pkg::CmdAlloc, n, $urandom);
      end else begin
        if ($urandom_range(0, 7) == 0) fp = $urandom_range(0, 1023);
        else fp = sb.lo_page() + $urandom_range(0, span);
        send(pra_pkg::CmdFree, $urandom, fp);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, exact and worst fit, break growth, frees at odd places.
    send(pra_pkg::CmdAlloc, 0, 0);
    send(pra_pkg::CmdAlloc, 4, 0);
    send(pra_pkg::CmdAlloc, 2, 0);
    send(pra_pkg::CmdAlloc, 3, 0);
    send(pra_pkg::CmdAlloc, 5, 0);
    send(pra_pkg::CmdFree, 0, 6);
    send(pra_pkg::CmdFree, 0, 0);
    send(pra_pkg::CmdAlloc, 3, 0);
    send(pra_pkg::CmdAlloc, 1, 0);
    send(pra_pkg::CmdFree, 0, 7);
    send(pra_pkg::CmdFree, 2047, 1023);
    send(pra_pkg::CmdAlloc, 1024, 0);
    send(pra_pkg::CmdAlloc, 2047, 1023);
    send(pra_pkg::CmdFree, 0, 9);
    send(pra_pkg::CmdFree, 0, 0);
    send(pra_pkg::CmdFree, 0, 4);
    send(pra_pkg::CmdAlloc, 11'h555, 10'h2aa);
    send(pra_pkg::CmdFree, 11'h2aa, 10'h155);
    go_idle();

    // Region at the top of the map, beyond it, then just below it.
    apb_write(1024);
    send(pra_pkg::CmdFree, 0, 1023);
    send(pra_pkg::CmdAlloc, 1, 0);
    go_idle();
    apb_write(2047);
    send(pra_pkg::CmdFree, 0, 1023);
    send(pra_pkg::CmdAlloc, 1, 0);
    go_idle();
    apb_write(1000);
    send(pra_pkg::CmdFree, 0, 999);
    send(pra_pkg::CmdAlloc, 24, 0);
    send(pra_pkg::CmdFree, 0, 1000);
    go_idle();

    apb_write(0);
    random_phase(180, 80);
    go_idle();

    // Fill the block while the receiver holds off.
    apb_write($urandom_range(1, 900));
    hold_off = 6000;
    random_phase(200, 60);
    go_idle();

    apb_write(0);
    calm = 1'b1;
    random_phase(180, 80);
    go_idle();

    $display("Covered %0d ok allocs, %0d ok frees, %0d no-space, %0d outside-region results",
             sb.n_alloc_ok, sb.n_free_ok, sb.n_nospace, sb.n_outside);
    $display("Region start changed across 0, 1000, 1024, 2047 and random values");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/pra_pkg.sv
rtl/pra_if.sv
rtl/pra_cell.sv
rtl/pra_ring.sv
rtl/page_run_allocator.sv
tb/pra_tb_pkg.sv
tb/tb_page_run_allocator.sv
